[rtl/rc4_pkg.sv]
// Shared types and constants for the RC4 stream cipher.
`default_nettype none

package rc4_pkg;

  // Data and table widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TABLE_D    = 256;
  localparam int unsigned TABLE_AW   = $clog2(TABLE_D);

  // Longest key kept; later key bytes are dropped
  localparam int unsigned KEY_MAX    = 256;
  localparam int unsigned KEY_CNT_W  = 9;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [TABLE_AW-1:0]  addr_t;
  typedef logic [KEY_CNT_W-1:0] key_cnt_t;

  // Request type codes
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

endpackage

`default_nettype wire

[rtl/rc4_if.sv]
// Valid/ready channel interfaces for the RC4 request and result streams.
`default_nettype none

interface rc4_in_if;
  logic           valid;
  logic           ready;
  logic           req_type;
  rc4_pkg::byte_t in_byte;
  logic           key_last;

  modport source (output valid, output req_type, output in_byte, output key_last,
                  input ready);
  modport sink   (input valid, input req_type, input in_byte, input key_last,
                  output ready);
endinterface

interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

[rtl/rc4_stream_cipher.sv]
// RC4 stream cipher: key store, key schedule sequencer and keystream datapath.
//
//  channel | dir | payload                        | transfer
//  --------+-----+--------------------------------+-----------------------
//  in_i    | in  | req_type, in_byte, key_last    | valid & ready
//  out_o   | out | out_byte                       | valid & ready
//
// A key byte without key_last is taken and the input stays ready. A key byte with
// key_last starts the key schedule: identity fill of all 256 entries, then per
// entry two reads and two swap writes; the input is not ready until it ends.
// The steps of a data byte are set by the single read and single write port of the
// permutation memory (two reads, two swap writes with the keystream read, output).
// Reset clears the indices, key count, state and output valid; both memories are
// left as they are and must be loaded with a key before data is sent.
// A stalled output holds its byte; the next item is still taken meanwhile.
`default_nettype none

module rc4_stream_cipher (
  input  wire         clk_i,
  input  wire         rst_ni,
  rc4_in_if.sink      in_i,
  rc4_out_if.source   out_o
);
  import rc4_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INIT     = 4'd1;
  localparam logic [3:0] ST_KS_RD_K  = 4'd2;
  localparam logic [3:0] ST_KS_RD_J  = 4'd3;
  localparam logic [3:0] ST_KS_WR_K  = 4'd4;
  localparam logic [3:0] ST_KS_WR_J  = 4'd5;
  localparam logic [3:0] ST_DT_RD_I  = 4'd6;
  localparam logic [3:0] ST_DT_RD_J  = 4'd7;
  localparam logic [3:0] ST_DT_WR_I  = 4'd8;
  localparam logic [3:0] ST_DT_WR_J  = 4'd9;
  localparam logic [3:0] ST_DT_OUT   = 4'd10;

  localparam addr_t    ADDR_LAST = addr_t'(TABLE_D - 1);
  localparam key_cnt_t KEY_LIMIT = key_cnt_t'(KEY_MAX);

  // Memories
  byte_t perm_mem [TABLE_D];
  byte_t key_mem  [TABLE_D];

  logic [3:0] state_q, state_d;
  addr_t      i_q, i_d;
  addr_t      j_q, j_d;
  addr_t      kpos_q, kpos_d;
  key_cnt_t   key_cnt_q, key_cnt_d;
  key_cnt_t   len_q, len_d;
  byte_t      si_q, si_d;
  byte_t      t_q, t_d;
  byte_t      byte_q, byte_d;
  logic       out_valid_q, out_valid_d;
  byte_t      out_byte_q, out_byte_d;

  byte_t      perm_rdata_q;
  byte_t      key_rdata_q;

  logic       perm_re, perm_we, key_re, key_we;
  addr_t      perm_raddr, perm_waddr;
  byte_t      perm_wdata;

  logic       in_xfer, out_free;
  key_cnt_t   key_cnt_inc;
  key_cnt_t   kpos_inc;
  byte_t      ks;
  addr_t      ks_j_sum;
  addr_t      dt_j_sum;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_xfer      = in_i.valid && in_i.ready;
  assign out_free     = !out_valid_q || out_o.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.out_byte = out_byte_q;

  // Key count after the current byte; saturates at the key limit
  assign key_cnt_inc = (key_cnt_q < KEY_LIMIT) ? key_cnt_q + key_cnt_t'(1) : key_cnt_q;
  assign kpos_inc    = key_cnt_t'(kpos_q) + key_cnt_t'(1);

  // Separate adders for j: one for the schedule, one for the data path
  assign ks_j_sum = j_q + key_rdata_q + perm_rdata_q;
  assign dt_j_sum = j_q + perm_rdata_q;

  // Keystream byte; forward si when the keystream read hit the entry S[j] written in the same cycle
  assign ks = (t_q == j_q) ? si_q : perm_rdata_q;

  // Key store write at the key transfer
  assign key_we = in_xfer && (in_i.req_type == REQ_KEY) && (key_cnt_q < KEY_LIMIT);
  assign key_re = (state_q == ST_KS_RD_K);

  // Sequencer and datapath control
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    kpos_d      = kpos_q;
    key_cnt_d   = key_cnt_q;
    len_d       = len_q;
    si_d        = si_q;
    t_d         = t_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    perm_re     = 1'b0;
    perm_we     = 1'b0;
    perm_raddr  = i_q;
    perm_waddr  = i_q;
    perm_wdata  = si_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_i.req_type == REQ_KEY) begin
            key_cnt_d = key_cnt_inc;
            if (in_i.key_last) begin
              len_d     = key_cnt_inc;
              key_cnt_d = '0;
              i_d       = '0;
              state_d   = ST_INIT;
            end
          end else begin
            byte_d  = in_i.in_byte;
            i_d     = i_q + addr_t'(1);
            state_d = ST_DT_RD_I;
          end
        end
      end
      ST_INIT: begin
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = byte_t'(i_q);
        i_d        = i_q + addr_t'(1);
        if (i_q == ADDR_LAST) begin
          j_d     = '0;
          kpos_d  = '0;
          state_d = ST_KS_RD_K;
        end
      end
      ST_KS_RD_K: begin
        perm_re    = 1'b1;
        perm_raddr = i_q;
        state_d    = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        si_d       = perm_rdata_q;
        j_d        = ks_j_sum;
        perm_re    = 1'b1;
        perm_raddr = ks_j_sum;
        state_d    = ST_KS_WR_K;
      end
      ST_KS_WR_K: begin
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rdata_q;
        state_d    = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = si_q;
        i_d        = i_q + addr_t'(1);
        kpos_d     = (kpos_inc >= len_q) ? '0 : kpos_inc[TABLE_AW-1:0];
        if (i_q == ADDR_LAST) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KS_RD_K;
        end
      end
      ST_DT_RD_I: begin
        perm_re    = 1'b1;
        perm_raddr = i_q;
        state_d    = ST_DT_RD_J;
      end
      ST_DT_RD_J: begin
        si_d       = perm_rdata_q;
        j_d        = dt_j_sum;
        perm_re    = 1'b1;
        perm_raddr = dt_j_sum;
        state_d    = ST_DT_WR_I;
      end
      ST_DT_WR_I: begin
        // rdata holds S[j]; it goes to S[i]
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rdata_q;
        t_d        = si_q + perm_rdata_q;
        state_d    = ST_DT_WR_J;
      end
      ST_DT_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = si_q;
        perm_re    = 1'b1;
        perm_raddr = t_q;
        state_d    = ST_DT_OUT;
      end
      ST_DT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte_q ^ ks;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      kpos_q      <= '0;
      key_cnt_q   <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      kpos_q      <= kpos_d;
      key_cnt_q   <= key_cnt_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    t_q        <= t_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
  end

  // Permutation memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rdata_q <= perm_mem[perm_raddr];
    end
  end

  // Key store
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_cnt_q[TABLE_AW-1:0]] <= in_i.in_byte;
    end
    if (key_re) begin
      key_rdata_q <= key_mem[kpos_q];
    end
  end

  // Checks
  a_out_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DT_OUT)
    else $error("result raised outside the output step");

  a_key_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= KEY_LIMIT)
    else $error("key count beyond the key limit");

  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KS_WR_J && i_q == ADDR_LAST) |=>
      (state_q == ST_IDLE && i_q == '0 && j_q == '0))
    else $error("key schedule did not end with cleared indices");

  a_data_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.req_type == REQ_DATA) |=> (state_q == ST_DT_RD_I && i_q == $past(i_q) + addr_t'(1)))
    else $error("data transfer did not advance index i");

  a_kpos_in_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KS_RD_K) |-> (key_cnt_t'(kpos_q) < len_q))
    else $error("key position outside the loaded key");

endmodule

`default_nettype wire
